/* rtl/ctps_pkg.sv */
`timescale 1ns / 1ps
package ctps_pkg;

  // Header body limits
  localparam int MAX_HEADER_BYTES = 4096;
  localparam int POS_W            = $clog2(MAX_HEADER_BYTES + 1);

  // Result kinds
  localparam logic [2:0] KIND_MAIN     = 3'd0;
  localparam logic [2:0] KIND_BOUNDARY = 3'd1;
  localparam logic [2:0] KIND_CHARSET  = 3'd2;
  localparam logic [2:0] KIND_NAME     = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;

  // Depth of the record queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One record per accepted byte that causes any result:
  // an optional span, then an optional end-of-header result
  typedef struct packed {
    logic        has_span;
    logic [2:0]  kind;
    logic [11:0] start;
    logic [12:0] len;
    logic        has_end;
  } ctps_rec_t;

endpackage

/* rtl/content_type_param_scanner_core.sv */
`timescale 1ns / 1ps
// A result passes through the registered record queue before it reaches the output ports.
// Throughput: one header byte per cycle while full is low; the final byte may give
// two results, popped in turn; a 4-record queue between scanner and output absorbs it.
// Reset: synchronous, active low; clears scan state and the queue, the body
// offset starts again at zero. The final byte also returns the scan to reset state.
module content_type_param_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_field_kind,
  output logic [11:0] out_span_start,
  output logic [12:0] out_span_length,
  output logic        out_end_of_header
);
  import ctps_pkg::*;

  logic      acc;
  logic      rec_push;
  ctps_rec_t rec;
  ctps_rec_t head;
  logic      q_empty;
  logic      q_pop;

  assign acc = push & ~full;

  ctps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  ctps_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_push),
    .wr_data (rec),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  ctps_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .field_kind    (out_field_kind),
    .span_start    (out_span_start),
    .span_length   (out_span_length),
    .end_of_header (out_end_of_header)
  );

endmodule

/* rtl/ctps_front.sv */
`timescale 1ns / 1ps
module ctps_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 rec_push,
  output ctps_pkg::ctps_rec_t  rec
);
  import ctps_pkg::*;

  typedef enum logic [5:0] {
    PH_MAIN_SKIP = 6'b000001,
    PH_MAIN_VAL  = 6'b000010,
    PH_KEY_SKIP  = 6'b000100,
    PH_KEY       = 6'b001000,
    PH_VAL_SKIP  = 6'b010000,
    PH_VAL       = 6'b100000
  } phase_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [2:0] ALL_KEYS = 3'b111;
  localparam logic [3:0] IDX_MAX  = 4'hF;

  // Key texts, first character in the top byte, zero padded
  localparam logic [63:0] KEY_TEXT [3] = '{
    64'h626F756E64617279,   // boundary
    64'h6368617273657400,   // charset
    64'h6E616D6500000000    // name
  };
  localparam logic [3:0] KEY_LEN [3] = '{4'd8, 4'd7, 4'd4};

  function automatic logic [2:0] kind_of(input logic [2:0] m);
    logic [2:0] k;
    begin
      if (m[0])      k = KIND_BOUNDARY;
      else if (m[1]) k = KIND_CHARSET;
      else if (m[2]) k = KIND_NAME;
      else           k = KIND_MAIN;
      return k;
    end
  endfunction

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   vb_r, vb_nxt;
  logic               quoted_r, quoted_nxt;
  logic [2:0]         mask_r, mask_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic               closed_r, closed_nxt;

  logic               active;
  logic               is_tab, is_sp, is_cr, is_lf, is_quote, is_semi, is_eq, is_ws;
  logic [7:0]         folded;
  logic [2:0]         kin_mask;
  logic [3:0]         kin_idx;
  logic               kin_closed;
  logic [2:0]         size_hit, chr_hit;
  logic               stop;
  logic               span_hit;
  logic [2:0]         span_kind;
  logic [POS_W-1:0]   span_vb;
  logic [POS_W-1:0]   span_len;

  // Classify the byte
  assign is_tab   = (data_byte == CH_TAB);
  assign is_sp    = (data_byte == CH_SP);
  assign is_cr    = (data_byte == CH_CR);
  assign is_lf    = (data_byte == CH_LF);
  assign is_quote = (data_byte == CH_QUOTE);
  assign is_semi  = (data_byte == CH_SEMI);
  assign is_eq    = (data_byte == CH_EQ);
  assign is_ws    = is_tab | is_sp | is_cr | is_lf;
  assign folded   = (data_byte >= 8'h41 && data_byte <= 8'h5A) ? data_byte + 8'h20 : data_byte;
  assign active   = (pos_r < POS_W'(MAX_HEADER_BYTES));

  // Key matcher inputs: a fresh key starts when the key skip ends
  assign kin_mask   = (phase_r == PH_KEY_SKIP) ? ALL_KEYS : mask_r;
  assign kin_idx    = (phase_r == PH_KEY_SKIP) ? 4'd0 : idx_r;
  assign kin_closed = (phase_r == PH_KEY_SKIP) ? 1'b0 : closed_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      size_hit[k] = (KEY_LEN[k] == kin_idx);
      chr_hit[k]  = (kin_idx < KEY_LEN[k]) &&
                    (KEY_TEXT[k][8*(7 - int'(kin_idx[2:0])) +: 8] == folded);
    end
  end

  assign stop = quoted_r ? (is_quote | is_cr | is_lf) : (is_semi | is_ws);

  // Scan one byte, then close the header on the final byte
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    vb_nxt     = vb_r;
    quoted_nxt = quoted_r;
    mask_nxt   = mask_r;
    idx_nxt    = idx_r;
    closed_nxt = closed_r;
    span_hit   = 1'b0;
    span_kind  = KIND_MAIN;
    span_vb    = vb_r;
    span_len   = '0;

    if (active) begin
      pos_nxt = POS_W'(pos_r + 1'b1);
      case (phase_r)
        PH_MAIN_SKIP: begin
          if (!(is_tab | is_sp | is_quote)) begin
            if (is_semi | is_cr | is_lf) begin
              phase_nxt = PH_KEY_SKIP;
            end else begin
              phase_nxt = PH_MAIN_VAL;
              vb_nxt    = pos_r;
            end
          end
        end
        PH_MAIN_VAL: begin
          if (is_semi | is_ws | is_quote) begin
            if (pos_r > vb_r) begin
              span_hit  = 1'b1;
              span_kind = KIND_MAIN;
              span_vb   = vb_r;
              span_len  = POS_W'(pos_r - vb_r);
            end
            phase_nxt = PH_KEY_SKIP;
          end
        end
        PH_KEY_SKIP, PH_KEY: begin
          if (phase_r == PH_KEY || !(is_semi | is_ws)) begin
            phase_nxt  = PH_KEY;
            mask_nxt   = kin_mask;
            idx_nxt    = kin_idx;
            closed_nxt = kin_closed;
            if (is_eq) begin
              mask_nxt  = kin_mask & size_hit;
              phase_nxt = PH_VAL_SKIP;
            end else if (!kin_closed) begin
              if (is_ws) begin
                closed_nxt = 1'b1;
              end else begin
                mask_nxt = kin_mask & chr_hit;
                if (kin_idx != IDX_MAX) idx_nxt = kin_idx + 4'd1;
              end
            end
          end
        end
        PH_VAL_SKIP: begin
          if (!is_ws) begin
            phase_nxt = PH_VAL;
            if (is_quote) begin
              quoted_nxt = 1'b1;
              vb_nxt     = POS_W'(pos_r + 1'b1);
            end else begin
              quoted_nxt = 1'b0;
              vb_nxt     = pos_r;
              // A bare value that stops at once is empty
              if (is_semi) begin
                if (mask_r != 3'b000) begin
                  span_hit  = 1'b1;
                  span_kind = kind_of(mask_r);
                  span_vb   = pos_r;
                  span_len  = '0;
                end
                phase_nxt = PH_KEY_SKIP;
              end
            end
          end
        end
        PH_VAL: begin
          if (stop) begin
            if (mask_r != 3'b000) begin
              span_hit  = 1'b1;
              span_kind = kind_of(mask_r);
              span_vb   = vb_r;
              span_len  = POS_W'(pos_r - vb_r);
            end
            phase_nxt = PH_KEY_SKIP;
          end
        end
        default: begin
          phase_nxt = PH_MAIN_SKIP;
        end
      endcase
    end

    if (last_byte) begin
      // Close a value still open at the end
      if (phase_nxt == PH_MAIN_VAL && pos_nxt > vb_nxt) begin
        span_hit  = 1'b1;
        span_kind = KIND_MAIN;
        span_vb   = vb_nxt;
        span_len  = POS_W'(pos_nxt - vb_nxt);
      end else if (phase_nxt == PH_VAL && mask_nxt != 3'b000) begin
        span_hit  = 1'b1;
        span_kind = kind_of(mask_nxt);
        span_vb   = vb_nxt;
        span_len  = (pos_nxt > vb_nxt) ? POS_W'(pos_nxt - vb_nxt) : '0;
      end
      phase_nxt  = PH_MAIN_SKIP;
      pos_nxt    = '0;
      vb_nxt     = '0;
      quoted_nxt = 1'b0;
      mask_nxt   = ALL_KEYS;
      idx_nxt    = '0;
      closed_nxt = 1'b0;
    end
  end

  // Build the record for the queue
  assign rec_push     = acc & (span_hit | last_byte);
  assign rec.has_span = span_hit;
  assign rec.kind     = span_kind;
  assign rec.start    = span_vb[11:0];
  assign rec.len      = 13'(span_len);
  assign rec.has_end  = last_byte;

  // Advance scan state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAIN_SKIP;
      pos_r    <= '0;
      vb_r     <= '0;
      quoted_r <= 1'b0;
      mask_r   <= ALL_KEYS;
      idx_r    <= '0;
      closed_r <= 1'b0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      vb_r     <= vb_nxt;
      quoted_r <= quoted_nxt;
      mask_r   <= mask_nxt;
      idx_r    <= idx_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

/* rtl/ctps_fifo.sv */
`timescale 1ns / 1ps
module ctps_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  ctps_pkg::ctps_rec_t  wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output ctps_pkg::ctps_rec_t  rd_data,
  output logic                 empty
);
  import ctps_pkg::*;

  ctps_rec_t          mem_r [QUEUE_DEPTH];
  ctps_rec_t          rd_data_r;
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = rd_data_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_wr ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    if (!do_wr && do_rd) cnt_nxt = QCNT_W'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store records, and fetch the next head, taking the incoming record when it lands there
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
    if (do_wr && (wr_ptr_r == rd_ptr_nxt)) rd_data_r <= wr_data;
    else rd_data_r <= mem_r[rd_ptr_nxt];
  end

endmodule

/* rtl/ctps_back.sv */
`timescale 1ns / 1ps
module ctps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctps_pkg::ctps_rec_t  head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           field_kind,
  output logic [11:0]          span_start,
  output logic [12:0]          span_length,
  output logic                 end_of_header
);
  import ctps_pkg::*;

  logic span_done_r, span_done_nxt;
  logic show_span;
  logic take;

  // Show the span first, then the end result of the same record
  assign show_span     = head.has_span & ~span_done_r;
  assign empty         = q_empty;
  assign field_kind    = show_span ? head.kind  : KIND_END;
  assign span_start    = show_span ? head.start : 12'd0;
  assign span_length   = show_span ? head.len   : 13'd0;
  assign end_of_header = ~show_span;

  // Drop the record once its last result is taken
  assign take = pop & ~q_empty;

  always_comb begin
    q_pop         = 1'b0;
    span_done_nxt = span_done_r;
    if (take) begin
      if (show_span && head.has_end) begin
        span_done_nxt = 1'b1;
      end else begin
        q_pop         = 1'b1;
        span_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_done_r <= 1'b0;
    end else begin
      span_done_r <= span_done_nxt;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import ctps_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BYTES = 950;
  localparam int DRAIN_CYCLES = 8;

  // Delimiter octets
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  typedef enum logic [5:0] {
    SCAN_MAIN_SKIP = 6'b000001,
    SCAN_MAIN_VAL  = 6'b000010,
    SCAN_KEY_SKIP  = 6'b000100,
    SCAN_KEY       = 6'b001000,
    SCAN_VAL_SKIP  = 6'b010000,
    SCAN_VAL       = 6'b100000
  } scan_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] start;
    logic [12:0] len;
    logic        eoh;
  } span_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        empty;
  logic        pop;
  logic [2:0]  out_field_kind;
  logic [11:0] out_span_start;
  logic [12:0] out_span_length;
  logic        out_end_of_header;

  // Scanner state mirrored by the span predictor
  scan_phase_t scan_phase;
  int          body_pos;
  int          val_start;
  logic        in_quotes;
  logic [2:0]  key_mask;
  int          key_idx;
  logic        key_done;
  string       key_names [3] = '{"boundary", "charset", "name"};

  span_t       span_q [$];
  span_t       want;
  logic [7:0]  hdr_bytes [$];
  bit          no_idle;
  int          n_errors;
  int          n_results;
  int          n_bytes;
  int          n_headers;
  int          n_cycles;

  content_type_param_scanner_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .empty             (empty),
    .pop               (pop),
    .out_field_kind    (out_field_kind),
    .out_span_start    (out_span_start),
    .out_span_length   (out_span_length),
    .out_end_of_header (out_end_of_header)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d spans outstanding", n_cycles, span_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == CH_TAB || b == CH_SP || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [2:0] kind_of_mask();
    if (key_mask[0]) return KIND_BOUNDARY;
    if (key_mask[1]) return KIND_CHARSET;
    if (key_mask[2]) return KIND_NAME;
    return KIND_MAIN;
  endfunction

  task automatic clear_scan();
    scan_phase = SCAN_MAIN_SKIP;
    body_pos   = 0;
    val_start  = 0;
    in_quotes  = 1'b0;
    key_mask   = 3'b111;
    key_idx    = 0;
    key_done   = 1'b0;
  endtask

  task automatic expect_span(logic [2:0] kind, int start, int len, logic eoh);
    span_t s;
    s.kind  = kind;
    s.start = start[11:0];
    s.len   = len[12:0];
    s.eoh   = eoh;
    span_q.push_back(s);
  endtask

  // Advance the scan by one in-range byte at offset pos
  task automatic scan_byte(logic [7:0] b, int pos);
    logic [7:0] c;
    logic       stop;
    if (scan_phase == SCAN_MAIN_SKIP) begin
      if (b == CH_TAB || b == CH_SP || b == CH_DQ) return;
      scan_phase = SCAN_MAIN_VAL;
      val_start  = pos;
    end
    if (scan_phase == SCAN_MAIN_VAL) begin
      if (b == CH_SEMI || is_space(b) || b == CH_DQ) begin
        if (pos > val_start) expect_span(KIND_MAIN, val_start, pos - val_start, 1'b0);
        scan_phase = SCAN_KEY_SKIP;
      end
      return;
    end
    if (scan_phase == SCAN_KEY_SKIP) begin
      if (b == CH_SEMI || is_space(b)) return;
      scan_phase = SCAN_KEY;
      key_mask   = 3'b111;
      key_idx    = 0;
      key_done   = 1'b0;
    end
    if (scan_phase == SCAN_KEY) begin
      if (b == CH_EQ) begin
        // keep only keys whose full text was seen
        for (int k = 0; k < 3; k++)
          if (key_names[k].len() != key_idx) key_mask[k] = 1'b0;
        scan_phase = SCAN_VAL_SKIP;
      end else if (!key_done) begin
        if (is_space(b)) begin
          key_done = 1'b1;
        end else begin
          c = to_lower(b);
          for (int k = 0; k < 3; k++)
            if (key_idx >= key_names[k].len() || key_names[k][key_idx] != c)
              key_mask[k] = 1'b0;
          if (key_idx < 15) key_idx++;
        end
      end
      return;
    end
    if (scan_phase == SCAN_VAL_SKIP) begin
      if (is_space(b)) return;
      scan_phase = SCAN_VAL;
      if (b == CH_DQ) begin
        in_quotes = 1'b1;
        val_start = pos + 1;
        return;
      end
      in_quotes = 1'b0;
      val_start = pos;
    end
    if (scan_phase == SCAN_VAL) begin
      stop = in_quotes ? (b == CH_DQ || b == CH_CR || b == CH_LF)
                       : (b == CH_SEMI || is_space(b));
      if (stop) begin
        if (key_mask != 3'b000) expect_span(kind_of_mask(), val_start, pos - val_start, 1'b0);
        scan_phase = SCAN_KEY_SKIP;
      end
    end
  endtask

  // Work out the spans caused by one accepted byte
  task automatic predict_spans(logic [7:0] b, logic fin);
    if (body_pos < MAX_HEADER_BYTES) begin
      scan_byte(b, body_pos);
      body_pos++;
    end
    if (fin) begin
      if (scan_phase == SCAN_MAIN_VAL && body_pos > val_start)
        expect_span(KIND_MAIN, val_start, body_pos - val_start, 1'b0);
      else if (scan_phase == SCAN_VAL && key_mask != 3'b000)
        expect_span(kind_of_mask(), val_start,
                    body_pos > val_start ? body_pos - val_start : 0, 1'b0);
      expect_span(KIND_END, 0, 0, 1'b1);
      clear_scan();
    end
  endtask

  // Push one byte, idling first for a random gap with junk on the data port
  task automatic send_byte(logic [7:0] d, logic fin);
    int gap;
    gap = rand_gap();
    repeat (gap) begin
      @(negedge clk);
      push         = 1'b0;
      in_data_byte = 8'($urandom);
      in_last_byte = 1'($urandom);
    end
    @(negedge clk);
    push         = 1'b1;
    in_data_byte = d;
    in_last_byte = fin;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_spans(d, fin);
    n_bytes++;
  endtask

  task automatic send_header();
    for (int i = 0; i < hdr_bytes.size(); i++)
      send_byte(hdr_bytes[i], i == hdr_bytes.size() - 1);
    hdr_bytes.delete();
    n_headers++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) hdr_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] token_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'(8'h61 + $urandom_range(0, 25) - ($urandom_range(0, 1) ? 8'd32 : 8'd0));
    if (r < 8) return $urandom_range(0, 1) ? 8'(8'h30 + $urandom_range(0, 9)) : 8'h2F;
    do c = 8'($urandom);
    while (is_space(c) || c == CH_DQ || c == CH_SEMI || c == CH_EQ);
    return c;
  endfunction

  // Key text, mostly one of the known keys in mixed case
  task automatic put_key();
    string s;
    logic [7:0] c;
    int pick;
    pick = $urandom_range(0, 6);
    s    = key_names[$urandom_range(0, 2)];
    if (pick == 3) s = s.substr(0, s.len() - 2);
    if (pick == 4) s = {s, "s"};
    if (pick == 5) begin
      repeat ($urandom_range(1, 10)) hdr_bytes.push_back(token_char());
      return;
    end
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if ($urandom_range(0, 1)) c = c - 8'd32;
      hdr_bytes.push_back(c);
    end
    if (pick == 6) put_text(" junk");
  endtask

  task automatic put_param();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: put_text(";");
      1: put_text("; ");
      2: put_text(";\r\n\t");
      3: put_text("\n");
      default: put_text(" ;");
    endcase
    put_key();
    if ($urandom_range(0, 3) == 0) put_text(" ");
    // drop the equals sign now and then
    if ($urandom_range(0, 11) != 0) hdr_bytes.push_back(CH_EQ);
    repeat ($urandom_range(0, 2))
      hdr_bytes.push_back($urandom_range(0, 1) ? CH_SP : ($urandom_range(0, 1) ? CH_TAB : CH_LF));
    if ($urandom_range(0, 2) == 0) begin
      hdr_bytes.push_back(CH_DQ);
      repeat ($urandom_range(0, 8)) begin
        do c = 8'($urandom);
        while (c == CH_DQ || c == CH_CR || c == CH_LF);
        hdr_bytes.push_back(c);
      end
      if ($urandom_range(0, 7) != 0) hdr_bytes.push_back(CH_DQ);
    end else begin
      repeat ($urandom_range(0, 8)) hdr_bytes.push_back(token_char());
    end
  endtask

  task automatic build_random_header();
    if ($urandom_range(0, 9) == 0) begin
      // raw noise over the whole byte range
      repeat ($urandom_range(1, 16)) hdr_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 2))
        hdr_bytes.push_back($urandom_range(0, 1) ? CH_SP : ($urandom_range(0, 1) ? CH_TAB : CH_DQ));
      repeat ($urandom_range(0, 6)) hdr_bytes.push_back(token_char());
      repeat ($urandom_range(0, 3)) put_param();
      if ($urandom_range(0, 7) == 0) put_text("; \r\n");
      // cut the header short now and then
      if ($urandom_range(0, 9) == 0 && hdr_bytes.size() > 1)
        hdr_bytes = hdr_bytes[0:$urandom_range(0, hdr_bytes.size() - 1)];
    end
    if (hdr_bytes.size() == 0) hdr_bytes.push_back(token_char());
  endtask

  task automatic test_directed();
    // one-byte body whose main value runs to the end
    hdr_bytes.push_back(8'hFF);
    send_header();
    // skip bytes only
    put_text("\t \"");
    send_header();
    // empty main value, and a quote as the final byte
    put_text(";name=\"");
    send_header();
    // upper-case key, whitespace after the equals sign, value to the end
    put_text("a;BOUNDARY= b");
    send_header();
  endtask

  task automatic test_overlong_body();
    // quote as the very last in-range byte, then bytes past the limit:
    // the open value ends at the limit and its offset wraps to zero
    put_text("x;");
    repeat (MAX_HEADER_BYTES - 8) hdr_bytes.push_back(CH_SP);
    put_text("name=\"");
    put_text("abcd");
    send_header();
  endtask

  task automatic test_random_headers();
    int first;
    first = n_bytes;
    while (n_bytes - first < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 5) == 0);
      build_random_header();
      send_header();
    end
    no_idle = 1'b0;
  endtask

  task automatic check_field(string fname, logic [12:0] want_v, logic [12:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", fname, want_v, got_v);
      n_errors++;
    end
  endtask

  // Compare each popped result with the oldest expected span
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (span_q.size() == 0) begin
        $error("unexpected result: field_kind %0d span_start %0d span_length %0d",
               out_field_kind, out_span_start, out_span_length);
        n_errors++;
      end else begin
        want = span_q.pop_front();
        check_field("field_kind", 13'(want.kind), 13'(out_field_kind));
        check_field("span_start", 13'(want.start), 13'(out_span_start));
        check_field("span_length", want.len, out_span_length);
        check_field("end_of_header", 13'(want.eoh), 13'(out_end_of_header));
        n_results++;
      end
    end
  end

  // Result side: bursts of pops with random stalls between them
  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      repeat ($urandom_range(1, 40)) begin
        @(negedge clk);
        pop = 1'b1;
      end
      repeat (rand_gap()) begin
        @(negedge clk);
        pop = 1'b0;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    no_idle      = 1'b0;
    n_errors     = 0;
    n_results    = 0;
    n_bytes      = 0;
    n_headers    = 0;
    n_cycles     = 0;
    clear_scan();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_overlong_body();
    test_random_headers();

    @(negedge clk);
    push = 1'b0;
    // drain outstanding spans, then watch for stray results
    while (span_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Scanned %0d headers (%0d bytes) incl. overlong and noise bodies;",
             n_headers, n_bytes);
    $display("checked %0d results, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
